// ----- sv/cfe_pkg.sv -----
// Shared types and constants for the cascaded feedback echo.
// Used by the comb cell, the top level and the testbench; depends on nothing.
`default_nettype none

package cfe_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int TDATA_W     = 2 * SAMPLE_W;
    localparam int ADDR_W      = 15;
    localparam int MAX_DELAY   = 1 << ADDR_W;
    localparam int DELAY_W     = 15;
    localparam int GAIN_W      = 16;
    localparam int FRAC_W      = GAIN_W - 1;
    localparam int FRAMES_W    = 16;
    localparam int MASK_W      = 2;
    localparam int NUM_STAGES  = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DELAY_ONE    = 3'd0,
        REG_DELAY_TWO    = 3'd1,
        REG_DELAY_THREE  = 3'd2,
        REG_GAIN_ONE     = 3'd3,
        REG_GAIN_TWO     = 3'd4,
        REG_GAIN_THREE   = 3'd5,
        REG_CHANNEL_MASK = 3'd6
    } cfg_reg_t;

    localparam logic [DELAY_W-1:0] DELAY_RST [NUM_STAGES] = '{15'd4800, 15'd12000, 15'd24000};
    localparam logic [GAIN_W-1:0]  GAIN_RST  [NUM_STAGES] = '{16'd24576, 16'd11469, 16'd4915};
    localparam logic [MASK_W-1:0]  MASK_RST = 2'b11;

    // Per-stage control worked out when the frame enters the chain.
    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic              tap_ok;    // store already holds the delayed frame
        logic              use_last;  // delay of one frame: take the held output
    } stage_ctrl_t;

    // One frame as it travels down the row of cells. Entry 0 of sc always
    // belongs to the cell that currently holds the frame.
    typedef struct packed {
        logic                              valid;
        logic [ADDR_W-1:0]                 pos;
        stage_ctrl_t [NUM_STAGES-1:0]      sc;
        logic signed [SAMPLE_W-1:0]        x_l;
        logic signed [SAMPLE_W-1:0]        x_r;
        logic signed [SAMPLE_W-1:0]        dry_l;
        logic signed [SAMPLE_W-1:0]        dry_r;
    } item_t;

endpackage

`default_nettype wire

// ----- sv/cfe_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; holds the delay line of one channel of one comb stage.
`default_nettype none

module cfe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/cfe_cell.sv -----
// One feedback comb stage for both channels: y = x + gain * y(delay frames ago).
// Depends on cfe_pkg and cfe_ram; the cells are chained in the top level.
`default_nettype none

module cfe_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic [cfe_pkg::GAIN_W-1:0]   gain,
    input  cfe_pkg::item_t               item_in,
    output cfe_pkg::item_t               item_out
);
    import cfe_pkg::*;

    localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
    localparam int FB_W   = SAMPLE_W + 2;
    localparam int SUM_W  = SAMPLE_W + 3;

    item_t                      r_reg;
    item_t                      out_reg;
    item_t                      out_next;
    logic signed [SAMPLE_W-1:0] ram_l;
    logic signed [SAMPLE_W-1:0] ram_r;
    logic signed [SAMPLE_W-1:0] tap_l;
    logic signed [SAMPLE_W-1:0] tap_r;
    logic signed [SAMPLE_W-1:0] y_l;
    logic signed [SAMPLE_W-1:0] y_r;
    logic signed [SAMPLE_W-1:0] last_l_reg;
    logic signed [SAMPLE_W-1:0] last_r_reg;
    logic                       wr_en;

    // Rounded feedback product (halves upwards), added to x and saturated.
    function automatic logic signed [SAMPLE_W-1:0] comb_step(
        input logic signed [SAMPLE_W-1:0] x,
        input logic signed [SAMPLE_W-1:0] tap,
        input logic        [GAIN_W-1:0]   g
    );
        logic signed [PROD_W-1:0] prod;
        logic signed [FB_W-1:0]   fb;
        logic signed [SUM_W-1:0]  sum;
        prod = PROD_W'(tap) * PROD_W'($signed({1'b0, g}));
        prod = prod + PROD_W'(1 << (FRAC_W - 1));
        fb   = prod[PROD_W-1:FRAC_W];
        sum  = SUM_W'(x) + SUM_W'(fb);
        if (sum[SUM_W-1:SAMPLE_W-1] == '0 || sum[SUM_W-1:SAMPLE_W-1] == '1) begin
            return sum[SAMPLE_W-1:0];
        end else if (sum[SUM_W-1]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

    assign wr_en = en & r_reg.valid;

    // The read for a frame is issued as it enters r_reg; the frame ahead of it
    // writes at the same edge, which never hits the same entry unless the
    // delay is one frame, and that case is served from the held output.
    cfe_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_DELAY)) u_ram_l (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (r_reg.pos),
        .wdata (y_l),
        .re    (en),
        .raddr (item_in.sc[0].rd_addr),
        .rdata (ram_l)
    );

    cfe_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_DELAY)) u_ram_r (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (r_reg.pos),
        .wdata (y_r),
        .re    (en),
        .raddr (item_in.sc[0].rd_addr),
        .rdata (ram_r)
    );

    always_comb begin
        if (!r_reg.sc[0].tap_ok) begin
            tap_l = '0;
            tap_r = '0;
        end else if (r_reg.sc[0].use_last) begin
            tap_l = last_l_reg;
            tap_r = last_r_reg;
        end else begin
            tap_l = ram_l;
            tap_r = ram_r;
        end
        y_l = comb_step(r_reg.x_l, tap_l, gain);
        y_r = comb_step(r_reg.x_r, tap_r, gain);
    end

    always_comb begin
        out_next     = r_reg;
        out_next.x_l = y_l;
        out_next.x_r = y_r;
        for (int i = 0; i < NUM_STAGES - 1; i++) begin
            out_next.sc[i] = r_reg.sc[i+1];
        end
        out_next.sc[NUM_STAGES-1] = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_reg.valid   <= 1'b0;
            out_reg.valid <= 1'b0;
        end else if (en) begin
            r_reg   <= item_in;
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            last_l_reg <= y_l;
            last_r_reg <= y_r;
        end
    end

    assign item_out = out_reg;

endmodule

`default_nettype wire

// ----- sv/cascaded_feedback_echo.sv -----
// Top level of the cascaded feedback echo: configuration registers, frame
// counters, the row of three comb cells and the output register.
// Depends on cfe_pkg and cfe_cell, and through cfe_cell on cfe_ram.
`default_nettype none

// Takes one stereo frame per clock while the output is not stalled and returns
// one frame per input. Each of the three comb cells first reads the delay memory
// for a frame, then multiplies, adds and saturates, and the output register
// follows the last cell. The recursion for a delay of one frame closes through
// a single multiply-add in each cell, which sets the clock limit. The delay lines
// are six memories of 32768 x 24 bits, one per stage and channel; they need no
// clearing after reset, since a tap reads as zero until the fill count has
// reached its delay. A stalled output holds the chain, but frames still enter
// while the last cell is empty.
module cascaded_feedback_echo (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [cfe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cfe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Input frames
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cfe_pkg::TDATA_W-1:0]       s_tdata,   // sample_left, sample_right
    input  logic                              s_tuser,   // start_of_stream
    // Result frames
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cfe_pkg::TDATA_W-1:0]       m_tdata    // out_left, out_right
);
    import cfe_pkg::*;

    logic [DELAY_W-1:0]          delay_reg [NUM_STAGES];
    logic [GAIN_W-1:0]           gain_reg  [NUM_STAGES];
    logic [MASK_W-1:0]           mask_reg;
    logic [ADDR_W-1:0]           pos_reg;
    logic [ADDR_W-1:0]           pos_next;
    logic [FRAMES_W-1:0]         frames_reg;
    logic [FRAMES_W-1:0]         frames_next;
    logic [FRAMES_W-1:0]         frames_base;
    logic [FRAMES_W-1:0]         eff_delay [NUM_STAGES];
    logic                        en;
    logic                        in_acc;
    item_t                       head_item;
    item_t                       chain [NUM_STAGES+1];
    item_t                       last_item;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic signed [SAMPLE_W-1:0]  out_l_reg;
    logic signed [SAMPLE_W-1:0]  out_r_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                delay_reg[i] <= DELAY_RST[i];
                gain_reg[i]  <= GAIN_RST[i];
            end
            mask_reg <= MASK_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DELAY_ONE:    delay_reg[0] <= cfg_wdata[DELAY_W-1:0];
                REG_DELAY_TWO:    delay_reg[1] <= cfg_wdata[DELAY_W-1:0];
                REG_DELAY_THREE:  delay_reg[2] <= cfg_wdata[DELAY_W-1:0];
                REG_GAIN_ONE:     gain_reg[0]  <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_TWO:     gain_reg[1]  <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_THREE:   gain_reg[2]  <= cfg_wdata[GAIN_W-1:0];
                REG_CHANNEL_MASK: mask_reg     <= cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // The chain moves unless a result waits and the last cell holds a frame.
    assign last_item = chain[NUM_STAGES];
    assign en        = m_tready | ~m_valid_reg | ~last_item.valid;
    assign s_tready  = en;
    assign in_acc    = s_tvalid & en;

    always_comb begin
        frames_base = s_tuser ? '0 : frames_reg;
        if (!in_acc) begin
            frames_next = frames_reg;
            pos_next    = pos_reg;
        end else begin
            frames_next = (frames_base == '1) ? frames_base : frames_base + 1'b1;
            pos_next    = pos_reg + 1'b1;
        end
    end

    // A delay of zero stands for the full memory depth.
    always_comb begin
        head_item.valid = s_tvalid;
        head_item.pos   = pos_reg;
        head_item.x_l   = $signed(s_tdata[SAMPLE_W-1:0]);
        head_item.x_r   = $signed(s_tdata[TDATA_W-1:SAMPLE_W]);
        head_item.dry_l = $signed(s_tdata[SAMPLE_W-1:0]);
        head_item.dry_r = $signed(s_tdata[TDATA_W-1:SAMPLE_W]);
        for (int i = 0; i < NUM_STAGES; i++) begin
            eff_delay[i] = (delay_reg[i] == '0) ? FRAMES_W'(MAX_DELAY)
                                                : FRAMES_W'(delay_reg[i]);
            head_item.sc[i].rd_addr  = pos_reg - delay_reg[i][ADDR_W-1:0];
            head_item.sc[i].tap_ok   = (frames_base >= eff_delay[i]);
            head_item.sc[i].use_last = (eff_delay[i] == FRAMES_W'(1));
        end
    end

    assign chain[0] = head_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            frames_reg <= '0;
        end else begin
            pos_reg    <= pos_next;
            frames_reg <= frames_next;
        end
    end

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
        cfe_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .gain     (gain_reg[g]),
            .item_in  (chain[g]),
            .item_out (chain[g+1])
        );
    end

    // Output register; a masked-off channel leaves with its dry sample.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (en && last_item.valid) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && last_item.valid) begin
            out_l_reg <= mask_reg[0] ? last_item.x_l : last_item.dry_l;
            out_r_reg <= mask_reg[1] ? last_item.x_r : last_item.dry_r;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_r_reg, out_l_reg};

endmodule

`default_nettype wire

// ----- tb/sv/cascaded_feedback_echo_test.sv -----
// Self-checking testbench for the cascaded feedback echo: drives stereo frames and
// configuration writes, predicts every result frame and compares it field by field.
// Depends on cfe_pkg and the cascaded_feedback_echo top level.
`timescale 1ns / 1ps

module cascaded_feedback_echo_test;

    import cfe_pkg::*;

    localparam int     CHANNELS    = 2;
    localparam longint SAMPLE_MAX  = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN  = -(longint'(1) <<< (SAMPLE_W - 1));
    localparam int     FILL_MAX    = (1 << FRAMES_W) - 1;
    localparam int     HOLD_CYCLES = 400;
    localparam int     QUIET_LIMIT = 5000;
    localparam int     SETTLE      = 20;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [SAMPLE_W-1:0]    SMAX = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0]    SMIN = 24'h800000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } echo_pair_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata   = '0;   // sample_left, sample_right
    logic                   s_tuser   = 1'b0; // start_of_stream
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;          // out_left, out_right

    cascaded_feedback_echo dut (.*);

    // Predicted state of the echo chain.
    logic [DELAY_W-1:0]  delay_set [NUM_STAGES];
    logic [GAIN_W-1:0]   gain_set  [NUM_STAGES];
    logic [MASK_W-1:0]   mask_set;
    bit signed [SAMPLE_W-1:0] comb_history [NUM_STAGES][CHANNELS][MAX_DELAY];
    int unsigned wr_pos;
    int unsigned fill_count;

    echo_pair_t echo_due [$];
    int mismatches = 0;
    int send_idle  = 0;
    int recv_idle  = 0;
    int hold_req   = 0;
    int hold_ack   = 0;
    int hold_left  = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Works out the result frame for one accepted input frame and advances the
    // predicted delay lines, write position and fill count.
    function automatic echo_pair_t echo_frame(input logic [SAMPLE_W-1:0] left,
                                              input logic [SAMPLE_W-1:0] right,
                                              input logic restart);
        echo_pair_t  res;
        int unsigned span  [NUM_STAGES];
        int unsigned rd_at [NUM_STAGES];
        bit          tap_on [NUM_STAGES];
        longint      acc;
        longint      tap;
        longint      dry;
        if (restart)
            fill_count = 0;
        for (int st = 0; st < NUM_STAGES; st++) begin
            span[st]   = (delay_set[st] == 0) ? MAX_DELAY : delay_set[st];
            rd_at[st]  = (wr_pos >= span[st]) ? wr_pos - span[st]
                                              : wr_pos + MAX_DELAY - span[st];
            tap_on[st] = fill_count >= span[st];
        end
        for (int ch = 0; ch < CHANNELS; ch++) begin
            dry = (ch == 0) ? longint'(signed'(left)) : longint'(signed'(right));
            acc = dry;
            for (int st = 0; st < NUM_STAGES; st++) begin
                // The tap is read before this frame overwrites the same entry,
                // which matters when the delay spans the whole line.
                tap = tap_on[st] ? longint'(comb_history[st][ch][rd_at[st]]) : 0;
                acc = acc + ((tap * longint'(gain_set[st]) + 16384) >>> FRAC_W);
                if (acc > SAMPLE_MAX)
                    acc = SAMPLE_MAX;
                else if (acc < SAMPLE_MIN)
                    acc = SAMPLE_MIN;
                comb_history[st][ch][wr_pos] = acc[SAMPLE_W-1:0];
            end
            if (!mask_set[ch])
                acc = dry;
            if (ch == 0)
                res.left = acc[SAMPLE_W-1:0];
            else
                res.right = acc[SAMPLE_W-1:0];
        end
        if (fill_count < FILL_MAX)
            fill_count++;
        wr_pos = (wr_pos + 1 == MAX_DELAY) ? 0 : wr_pos + 1;
        return res;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 19))
            0: return SMAX;
            1: return SMIN;
            2: return '0;
            3: return '1;
            4, 5, 6, 7, 8: return SAMPLE_W'($urandom_range(0, 511) - 256);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Moderate amplitude, so that long echo tails do not sit in saturation.
    function automatic logic [SAMPLE_W-1:0] quiet_sample();
        return SAMPLE_W'($urandom_range(0, 131071) - 65536);
    endfunction

    task automatic report_mismatch(input string field, input logic [SAMPLE_W-1:0] want,
                                   input logic [SAMPLE_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at %0t: expected %h, got %h", field, $time, want, got);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_DELAY_ONE:    delay_set[0] = value[DELAY_W-1:0];
            REG_DELAY_TWO:    delay_set[1] = value[DELAY_W-1:0];
            REG_DELAY_THREE:  delay_set[2] = value[DELAY_W-1:0];
            REG_GAIN_ONE:     gain_set[0]  = value[GAIN_W-1:0];
            REG_GAIN_TWO:     gain_set[1]  = value[GAIN_W-1:0];
            REG_GAIN_THREE:   gain_set[2]  = value[GAIN_W-1:0];
            REG_CHANNEL_MASK: mask_set     = value[MASK_W-1:0];
            default: ;
        endcase
    endtask

    // Offers one frame, with random idle cycles ahead of it, and records the
    // expected result once the transaction completes.
    task automatic send_frame(input logic [SAMPLE_W-1:0] left,
                              input logic [SAMPLE_W-1:0] right, input logic restart);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        s_tuser  <= restart;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        echo_due.push_back(echo_frame(left, right, restart));
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (echo_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic random_setup();
        logic [CFG_DATA_W-1:0] word;
        for (int st = 0; st < NUM_STAGES; st++) begin
            case ($urandom_range(0, 9))
                0: word = 16'd1;
                1: word = 16'h7FFF;
                2: word = 16'h8000;   // masks down to zero, the longest delay
                default: word = 16'($urandom_range(1, 48));
            endcase
            word[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
            write_register(CFG_INDEX_W'(REG_DELAY_ONE + st), word);
            case ($urandom_range(0, 9))
                0, 1: word = 16'd0;
                2: word = 16'hFFFF;
                3: word = 16'h8000;
                default: word = 16'($urandom_range(0, 65535));
            endcase
            write_register(CFG_INDEX_W'(REG_GAIN_ONE + st), word);
        end
        write_register(REG_CHANNEL_MASK, 16'($urandom_range(0, 65535)));
        if ($urandom_range(0, 3) == 0)
            write_register(REG_UNUSED, 16'($urandom_range(0, 65535)));
    endtask

    // Runs from reset on the power-up settings; every tap stays silent while
    // the fill count is below the shortest default delay.
    task automatic test_reset_defaults();
        send_idle = 0;
        recv_idle <= 0;
        for (int i = 0; i < 100; i++)
            send_frame(quiet_sample(), quiet_sample(), 1'b0);
        wait_for_results();
    endtask

    task automatic test_directed();
        send_idle = 25;
        recv_idle <= 72;
        write_register(REG_DELAY_ONE, 16'd1);
        write_register(REG_DELAY_TWO, 16'd2);
        write_register(REG_DELAY_THREE, 16'd3);
        write_register(REG_GAIN_ONE, 16'hFFFF);
        write_register(REG_GAIN_TWO, 16'h8000);
        write_register(REG_GAIN_THREE, 16'h4000);
        write_register(REG_CHANNEL_MASK, 16'hFFFF);
        write_register(REG_UNUSED, 16'hFFFF);
        send_frame(SMAX, SMIN, 1'b1);
        send_frame(SMAX, SMIN, 1'b0);
        send_frame(SMIN, SMAX, 1'b0);
        send_frame('0, '1, 1'b0);
        send_frame(24'd1, '1, 1'b0);
        send_frame(24'h555555, 24'hAAAAAA, 1'b0);
        send_frame(24'hAAAAAA, 24'h555555, 1'b0);
        send_frame('0, '0, 1'b0);
        // A restart mid-stream must silence the taps again although the lines hold data.
        send_frame(24'd1, '1, 1'b1);
        send_frame('0, '0, 1'b0);
        send_frame('0, '0, 1'b0);
        send_frame('0, '0, 1'b0);
        wait_for_results();
        // Second stage bypassed, first delay masked to zero, left channel only.
        write_register(REG_GAIN_ONE, 16'd1);
        write_register(REG_GAIN_TWO, 16'd0);
        write_register(REG_GAIN_THREE, 16'hFFFF);
        write_register(REG_DELAY_ONE, 16'h8000);
        write_register(REG_CHANNEL_MASK, 16'd1);
        send_frame(24'd1, 24'd1, 1'b1);
        send_frame(24'h000100, 24'hFFFF00, 1'b0);
        send_frame('0, '0, 1'b0);
        send_frame('0, '0, 1'b0);
        wait_for_results();
        write_register(REG_CHANNEL_MASK, 16'd2);
        send_frame(SMIN, SMAX, 1'b0);
        send_frame('0, '0, 1'b0);
        wait_for_results();
        write_register(REG_CHANNEL_MASK, 16'd0);
        send_frame(SMAX, SMIN, 1'b0);
        send_frame('0, '0, 1'b0);
        wait_for_results();
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input bit squeeze);
        send_idle = send_pct;
        recv_idle <= recv_pct;
        for (int seg = 0; seg < 4; seg++) begin
            random_setup();
            for (int i = 0; i < 80; i++) begin
                send_frame(pick_sample(), pick_sample(), $urandom_range(0, 39) == 0);
                // The receiver then holds off while frames keep coming, so the
                // chain fills and the input stalls.
                if (squeeze && seg == 1 && i == 20)
                    hold_req <= hold_req + 1;
            end
            wait_for_results();
        end
    endtask

    // Delays at the top of the range: the taps must stay silent while the
    // fill count is still below them.
    task automatic test_long_span();
        send_idle = 0;
        recv_idle <= 0;
        write_register(REG_DELAY_ONE, 16'hFFFF);
        write_register(REG_DELAY_TWO, 16'h8000);
        write_register(REG_DELAY_THREE, 16'd20000);
        write_register(REG_GAIN_ONE, 16'd24576);
        write_register(REG_GAIN_TWO, 16'd32768);
        write_register(REG_GAIN_THREE, 16'd40000);
        write_register(REG_CHANNEL_MASK, 16'd3);
        send_frame(quiet_sample(), quiet_sample(), 1'b1);
        for (int i = 0; i < 100; i++)
            send_frame(quiet_sample(), quiet_sample(), 1'b0);
        wait_for_results();
    endtask

    always @(posedge aclk) begin : result_side
        echo_pair_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (echo_due.size() == 0) begin
                report_mismatch("unexpected result", 'x, m_tdata[SAMPLE_W-1:0]);
            end else begin
                due = echo_due.pop_front();
                if (m_tdata[SAMPLE_W-1:0] !== due.left)
                    report_mismatch("out_left", due.left, m_tdata[SAMPLE_W-1:0]);
                if (m_tdata[TDATA_W-1:SAMPLE_W] !== due.right)
                    report_mismatch("out_right", due.right, m_tdata[TDATA_W-1:SAMPLE_W]);
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= $urandom_range(0, 99) >= recv_idle;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("cascaded_feedback_echo test failed");
        $finish;
    end

    initial begin
        delay_set  = DELAY_RST;
        gain_set   = GAIN_RST;
        mask_set   = MASK_RST;
        wr_pos     = 0;
        fill_count = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_random(25, 72, 1'b1);
        test_random(72, 25, 1'b0);
        test_random(0, 0, 1'b0);
        test_long_span();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && echo_due.size() == 0)
            $display("cascaded_feedback_echo test passed");
        else
            $display("cascaded_feedback_echo test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/cfe_pkg.sv
sv/cfe_ram.sv
sv/cfe_cell.sv
sv/cascaded_feedback_echo.sv
tb/sv/cascaded_feedback_echo_test.sv
